// ===== hdl/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, constants and helpers for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int VTX_COUNT = 1024;                 // 4 .. 65536
  localparam int ADDR_W    = $clog2(VTX_COUNT);
  localparam int IDX_W     = 10;
  localparam int IDX_EXT_W = 17;                   // holds any index and VTX_COUNT
  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = 36;
  localparam int SUM_W     = 48;
  localparam int POS_W     = 3 * COORD_W;
  localparam int SUMS_W    = 3 * SUM_W;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 144;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VTX_COUNT - 1);
  localparam logic [2:0]        CROSS_LAST_STEP = 3'd6;

  typedef enum logic [1:0] {
    CMD_WRITE_VTX   = 2'd0,
    CMD_ADD_FACE    = 2'd1,
    CMD_READ_NORMAL = 2'd2,
    CMD_CLEAR       = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pos_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] z;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] x;
  } sum_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] z;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] x;
  } cross_t;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return IDX_EXT_W'(idx) < IDX_EXT_W'(VTX_COUNT);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] idx);
    logic [IDX_EXT_W-1:0] ext;
    ext = IDX_EXT_W'(idx);
    return ext[ADDR_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]   acc,
    input logic signed [CROSS_W-1:0] term
  );
    logic signed [SUM_W:0] s;
    s = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - CROSS_W){term[CROSS_W-1]}}, term};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

// ===== hdl/vertex_normal_accumulator.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted vertex normals: position store, per-vertex saturating
// 48-bit accumulators, one shared multiplier for the face cross product.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           contents
//  s_*      in   s_tvalid/s_tready   command in s_tuser, vertex/face in s_tdata
//  m_*      out  m_tvalid/m_tready   normal_x/y/z, only for read-normal
//
//  Write-vertex leaves the sequencer idle; read-normal passes S_RNRD and
//  S_RNOUT plus any output stall; add-face does 3 position reads, 6 multiplier
//  steps, then a read-modify-write of each corner on the single-port
//  accumulator RAM. Clear sweeps the accumulator RAM one entry a cycle.
//  The same sweep runs after reset; s_tready stays low until it ends.
//  s_tready is high only while the sequencer idles.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator import vna_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // command
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // normal_x, normal_y, normal_z
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_RDPOS = 8'b0000_0100,
    S_CROSS = 8'b0000_1000,
    S_RDSUM = 8'b0001_0000,
    S_WRSUM = 8'b0010_0000,
    S_RNRD  = 8'b0100_0000,
    S_RNOUT = 8'b1000_0000
  } state_t;

  state_t             state;
  logic [1:0]         cnt;
  logic [ADDR_W-1:0]  clr_addr;
  logic               cross_start;
  logic               cross_done;
  cross_t             nvec;

  logic [IDX_W-1:0]   idx_r, cor_a, cor_b, cor_c;
  logic               idx_ok;
  pos_t               pa, pb, pc;

  // input fields
  cmd_t               in_cmd;
  logic [IDX_W-1:0]   in_idx, in_a, in_b, in_c;
  pos_t               in_pos;
  logic               accept;
  logic [IDX_W-1:0]   corner_sel;
  logic               out_load;

  logic               pos_we;
  logic [ADDR_W-1:0]  pos_addr;
  pos_t               pos_rd;
  logic               sum_we;
  logic [ADDR_W-1:0]  sum_addr;
  sum_t               sum_wd, sum_rd;

  assign in_cmd   = cmd_t'(s_tuser);
  assign in_idx   = s_tdata[9:0];
  assign in_pos.x = s_tdata[25:10];
  assign in_pos.y = s_tdata[41:26];
  assign in_pos.z = s_tdata[57:42];
  assign in_a     = s_tdata[67:58];
  assign in_b     = s_tdata[77:68];
  assign in_c     = s_tdata[87:78];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // output register takes a new item when empty or being drained
  assign out_load = (state == S_RNOUT) && (!m_tvalid || m_tready);

  always_comb begin
    case (cnt)
      2'd0:    corner_sel = cor_a;
      2'd1:    corner_sel = cor_b;
      default: corner_sel = cor_c;
    endcase
  end

  assign pos_we   = accept && (in_cmd == CMD_WRITE_VTX) && in_range(in_idx);
  assign pos_addr = (state == S_IDLE) ? addr_of(in_idx) : addr_of(corner_sel);

  always_comb begin
    sum_we   = 1'b0;
    sum_addr = addr_of(corner_sel);
    sum_wd.x = sat_add(sum_rd.x, nvec.x);
    sum_wd.y = sat_add(sum_rd.y, nvec.y);
    sum_wd.z = sat_add(sum_rd.z, nvec.z);
    case (state)
      S_CLEAR: begin
        sum_we   = 1'b1;
        sum_addr = clr_addr;
        sum_wd   = '0;
      end
      S_WRSUM: sum_we = 1'b1;
      S_RNRD, S_RNOUT: sum_addr = addr_of(idx_r);
      default: ;
    endcase
  end

  vna_ram #(.WIDTH(POS_W), .DEPTH(VTX_COUNT)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .addr  (pos_addr),
    .wdata (in_pos),
    .rdata (pos_rd)
  );

  vna_ram #(.WIDTH(SUMS_W), .DEPTH(VTX_COUNT)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .addr  (sum_addr),
    .wdata (sum_wd),
    .rdata (sum_rd)
  );

  vna_cross u_cross (
    .clk   (clk),
    .rst   (rst),
    .start (cross_start),
    .pa    (pa),
    .pb    (pb),
    .pc    (pc),
    .done  (cross_done),
    .nvec  (nvec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      cnt         <= '0;
      cross_start <= 1'b0;
    end else begin
      cross_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_ADD_FACE: begin
                if (in_range(in_a) && in_range(in_b) && in_range(in_c)) begin
                  state <= S_RDPOS;
                  cnt   <= '0;
                end
              end
              CMD_READ_NORMAL: state <= S_RNRD;
              CMD_CLEAR: begin
                state    <= S_CLEAR;
                clr_addr <= '0;
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_RDPOS: begin
          // read issued for corner cnt, data for corner cnt-1 arrives
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state       <= S_CROSS;
            cross_start <= 1'b1;
          end
        end
        S_CROSS: begin
          if (cross_done) begin
            state <= S_RDSUM;
            cnt   <= '0;
          end
        end
        S_RDSUM: state <= S_WRSUM;
        S_WRSUM: begin
          if (cnt == 2'd2) begin
            state <= S_IDLE;
          end else begin
            cnt   <= cnt + 2'd1;
            state <= S_RDSUM;
          end
        end
        S_RNRD: state <= S_RNOUT;
        S_RNOUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= in_idx;
      idx_ok <= in_range(in_idx);
      cor_a  <= in_a;
      cor_b  <= in_b;
      cor_c  <= in_c;
    end
    if (state == S_RDPOS) begin
      case (cnt)
        2'd1:    pa <= pos_rd;
        2'd2:    pb <= pos_rd;
        2'd3:    pc <= pos_rd;
        default: ;
      endcase
    end
    if (out_load) begin
      m_tdata <= idx_ok ? sum_rd : '0;
    end
  end

endmodule

// ===== hdl/vna_ram.sv =====
// ----------------------------------------------------------------------------
// vna_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/vna_cross.sv =====
// ----------------------------------------------------------------------------
// vna_cross
// Cross product of (b - a) and (c - a) on one shared 17x17 multiplier,
// six products in turn, folded into the three components.
// ----------------------------------------------------------------------------
module vna_cross import vna_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  pos_t   pa,
  input  pos_t   pb,
  input  pos_t   pc,
  output logic   done,
  output cross_t nvec
);

  logic signed [DIFF_W-1:0] ux, uy, uz, wx, wy, wz;
  logic signed [DIFF_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic                     busy;
  logic [2:0]               step;

  always_comb begin
    case (step)
      3'd0:    begin op_a = uy; op_b = wz; end
      3'd1:    begin op_a = uz; op_b = wy; end
      3'd2:    begin op_a = uz; op_b = wx; end
      3'd3:    begin op_a = ux; op_b = wz; end
      3'd4:    begin op_a = ux; op_b = wy; end
      3'd5:    begin op_a = uy; op_b = wx; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == CROSS_LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ux <= {pb.x[COORD_W-1], pb.x} - {pa.x[COORD_W-1], pa.x};
      uy <= {pb.y[COORD_W-1], pb.y} - {pa.y[COORD_W-1], pa.y};
      uz <= {pb.z[COORD_W-1], pb.z} - {pa.z[COORD_W-1], pa.z};
      wx <= {pc.x[COORD_W-1], pc.x} - {pa.x[COORD_W-1], pa.x};
      wy <= {pc.y[COORD_W-1], pc.y} - {pa.y[COORD_W-1], pa.y};
      wz <= {pc.z[COORD_W-1], pc.z} - {pa.z[COORD_W-1], pa.z};
    end
    if (busy) begin
      prod <= op_a * op_b;
      // product of the previous step lands here
      case (step)
        3'd1:    nvec.x <= CROSS_W'(prod);
        3'd2:    nvec.x <= nvec.x - CROSS_W'(prod);
        3'd3:    nvec.y <= CROSS_W'(prod);
        3'd4:    nvec.y <= nvec.y - CROSS_W'(prod);
        3'd5:    nvec.z <= CROSS_W'(prod);
        3'd6:    nvec.z <= nvec.z - CROSS_W'(prod);
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/vna_checker.sv =====
// ----------------------------------------------------------------------------
// vna_checker
// Port-level checks of the vertex normal accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module vna_checker import vna_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [1:0]             s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // reset starts the clearing sweep and drops any pending result
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("not busy or result pending after reset");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_WRITE_VTX) |=> s_tready)
    else $error("write-vertex held the block busy");

  a_long_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && ((s_tuser == CMD_READ_NORMAL) || (s_tuser == CMD_CLEAR))
    |=> !s_tready)
    else $error("ready right after read-normal or clear");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);

// ===== tb/sv/vertex_normal_accumulator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_tb
// Self-checking bench: vertex writes, face accumulation, normal reads and
// clears go through the input stream. A local model of the position store and
// the saturating per-vertex sums predicts every normal read, which is then
// compared axis by axis with the output stream. Random gaps are inserted on
// the sender side and random stalls on the receiver side. A run of repeated
// faces on one extreme triangle builds up large sums.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_tb;
  import vna_pkg::*;

  localparam int  LIMIT_CYCLES = 2_500_000;
  localparam int  RANDOM_ITEMS = 1000;
  localparam int  TAIL_LATENCY = 40;
  localparam longint SUM_HI    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO    = -SUM_HI - 1;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [1:0]             s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  vertex_normal_accumulator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model of the block
  logic signed [COORD_W-1:0] vtx_x [VTX_COUNT];
  logic signed [COORD_W-1:0] vtx_y [VTX_COUNT];
  logic signed [COORD_W-1:0] vtx_z [VTX_COUNT];
  bit                        vtx_known [VTX_COUNT];
  int                        known_list [$];
  longint                    acc_x [VTX_COUNT];
  longint                    acc_y [VTX_COUNT];
  longint                    acc_z [VTX_COUNT];
  sum_t                      pending_normals [$];

  bit sender_idles    = 1'b1;
  bit receiver_stalls = 1'b1;
  int stall_left      = 0;
  int cycle_count     = 0;
  int fail_count      = 0;
  int mismatch_count  = 0;
  int items_sent      = 0;
  int normals_checked = 0;
  int faces_sent      = 0;
  int clears_sent     = 0;

  function automatic longint clamp_add(input longint acc, input longint term);
    longint s;
    s = acc + term;
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  task automatic zero_sums();
    for (int i = 0; i < VTX_COUNT; i++) begin
      acc_x[i] = 0;
      acc_y[i] = 0;
      acc_z[i] = 0;
    end
  endtask

  task automatic accumulate_face(input int a, input int b, input int c);
    longint ux, uy, uz, wx, wy, wz, nx, ny, nz;
    int corner [3];
    ux = longint'(vtx_x[b]) - longint'(vtx_x[a]);
    uy = longint'(vtx_y[b]) - longint'(vtx_y[a]);
    uz = longint'(vtx_z[b]) - longint'(vtx_z[a]);
    wx = longint'(vtx_x[c]) - longint'(vtx_x[a]);
    wy = longint'(vtx_y[c]) - longint'(vtx_y[a]);
    wz = longint'(vtx_z[c]) - longint'(vtx_z[a]);
    nx = uy * wz - uz * wy;
    ny = uz * wx - ux * wz;
    nz = ux * wy - uy * wx;
    corner[0] = a;
    corner[1] = b;
    corner[2] = c;
    // repeated corners get the term once per occurrence
    foreach (corner[k]) begin
      acc_x[corner[k]] = clamp_add(acc_x[corner[k]], nx);
      acc_y[corner[k]] = clamp_add(acc_y[corner[k]], ny);
      acc_z[corner[k]] = clamp_add(acc_z[corner[k]], nz);
    end
  endtask

  task automatic predict_item(input cmd_t cmd, input int vidx,
                              input logic signed [COORD_W-1:0] px, py, pz,
                              input int ca, cb, cc);
    sum_t n;
    case (cmd)
      CMD_WRITE_VTX: begin
        vtx_x[vidx] = px;
        vtx_y[vidx] = py;
        vtx_z[vidx] = pz;
        if (!vtx_known[vidx]) known_list.insert(known_list.size(), vidx);
        vtx_known[vidx] = 1'b1;
      end
      CMD_ADD_FACE: begin
        accumulate_face(ca, cb, cc);
        faces_sent++;
      end
      CMD_READ_NORMAL: begin
        n.x = acc_x[vidx][SUM_W-1:0];
        n.y = acc_y[vidx][SUM_W-1:0];
        n.z = acc_z[vidx][SUM_W-1:0];
        pending_normals.insert(pending_normals.size(), n);
      end
      default: begin
        zero_sums();
        clears_sent++;
      end
    endcase
  endtask

  // one item on the input stream; s_tvalid is left high on return
  task automatic send_item(input cmd_t cmd, input logic [IDX_W-1:0] vidx,
                           input logic signed [COORD_W-1:0] px, py, pz,
                           input logic [IDX_W-1:0] ca, cb, cc);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {cc, cb, ca, pz, py, px, vidx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    predict_item(cmd, int'(vidx), px, py, pz, int'(ca), int'(cb), int'(cc));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_idx();
    return IDX_W'($urandom_range(0, VTX_COUNT - 1));
  endfunction

  function automatic logic [IDX_W-1:0] pick_known();
    return IDX_W'(known_list[$urandom_range(0, known_list.size() - 1)]);
  endfunction

  task automatic write_vertex(input int vidx, input logic signed [COORD_W-1:0] px, py, pz);
    send_item(CMD_WRITE_VTX, IDX_W'(vidx), px, py, pz, rand_idx(), rand_idx(), rand_idx());
  endtask

  task automatic add_face(input int a, input int b, input int c);
    send_item(CMD_ADD_FACE, rand_idx(), rand_coord(), rand_coord(), rand_coord(),
              IDX_W'(a), IDX_W'(b), IDX_W'(c));
  endtask

  task automatic read_normal(input int vidx);
    send_item(CMD_READ_NORMAL, IDX_W'(vidx), rand_coord(), rand_coord(), rand_coord(),
              rand_idx(), rand_idx(), rand_idx());
  endtask

  task automatic clear_sums();
    send_item(CMD_CLEAR, rand_idx(), rand_coord(), rand_coord(), rand_coord(),
              rand_idx(), rand_idx(), rand_idx());
  endtask

  // result checking
  task automatic check_axis(input string axis, input logic [SUM_W-1:0] want,
                            input logic [SUM_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch normal_%s: expected %0d, got %0d (cycle %0d)", axis,
                 $signed(want), $signed(got), cycle_count);
    end
  endtask

  task automatic check_normal(input sum_t got);
    sum_t want;
    if (pending_normals.size() == 0) begin
      fail_count++;
      $display("unexpected result at cycle %0d", cycle_count);
    end else begin
      want = pending_normals.pop_front();
      normals_checked++;
      check_axis("x", want.x, got.x);
      check_axis("y", want.y, got.y);
      check_axis("z", want.z, got.z);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_normal(sum_t'(m_tdata));
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[vertex_normal_accumulator] ERROR");
      $finish;
    end
  end

  // tests
  task automatic test_sums_after_reset();
    read_normal(0);
    read_normal(VTX_COUNT - 1);
  endtask

  task automatic test_directed_faces();
    // triangle whose face term hits about 2^32 on every axis
    write_vertex(1021, 16'sh8000, 16'sh8000, 16'sh8000);
    write_vertex(1022, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    write_vertex(1023, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    // unit triangle in Q8.8
    write_vertex(3, 16'sh0000, 16'sh0000, 16'sh0000);
    write_vertex(4, 16'sh0100, 16'sh0000, 16'sh0000);
    write_vertex(5, 16'sh0000, 16'sh0100, 16'sh0000);
    add_face(3, 4, 5);
    add_face(1021, 1022, 1023);
    // degenerate faces leave the sums alone
    add_face(3, 3, 5);
    add_face(4, 4, 4);
    read_normal(3);
    read_normal(4);
    read_normal(5);
    read_normal(1021);
    read_normal(1022);
    read_normal(1023);
    // clear keeps positions, so the same triangle works again
    clear_sums();
    read_normal(1022);
    add_face(1023, 1021, 1022);
    read_normal(1023);
    read_normal(5);
  endtask

  task automatic test_random_mix();
    int a, b, c, pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      if (i == RANDOM_ITEMS - 150) begin
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // favor a small pool so the sums build up
        if ($urandom_range(0, 3) != 0) write_vertex($urandom_range(0, 31), rand_coord(),
                                                    rand_coord(), rand_coord());
        else write_vertex(int'(rand_idx()), rand_coord(), rand_coord(), rand_coord());
      end else if (pick < 71) begin
        a = int'(pick_known());
        b = int'(pick_known());
        c = int'(pick_known());
        if ($urandom_range(0, 9) == 0) b = a;
        else if ($urandom_range(0, 9) == 0) c = b;
        add_face(a, b, c);
      end else if (pick < 98) begin
        if ($urandom_range(0, 4) < 3) read_normal(int'(pick_known()));
        else read_normal(int'(rand_idx()));
      end else begin
        clear_sums();
      end
    end
  endtask

  task automatic test_large_sums();
    clear_sums();
    write_vertex(1021, 16'sh8000, 16'sh8000, 16'sh8000);
    write_vertex(1022, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    write_vertex(1023, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    // each face adds about 2^32 per axis, so the sums grow to about 2^39
    for (int i = 0; i < 128; i++) add_face(1021, 1022, 1023);
    read_normal(1021);
    read_normal(1022);
    read_normal(1023);
    // reversed winding pulls the sums back by one face term
    add_face(1021, 1023, 1022);
    read_normal(1021);
    read_normal(1023);
  endtask

  initial begin
    zero_sums();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_sums_after_reset();
    test_directed_faces();
    test_random_mix();
    test_large_sums();
    drain();
    repeat (TAIL_LATENCY) @(posedge clk);
    if (pending_normals.size() != 0) begin
      fail_count++;
      $display("%0d normal reads never answered", pending_normals.size());
    end
    $display("sent %0d items: %0d faces, %0d clears; checked %0d normal reads",
             items_sent, faces_sent, clears_sent, normals_checked);
    $display("covered extreme coordinates, degenerate faces, clears and large sums");
    if (fail_count == 0) begin
      $display("[vertex_normal_accumulator] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[vertex_normal_accumulator] ERROR");
    end
    $finish;
  end

endmodule
